// File: rtl/core/csl_pkg.sv
// Package for the current clamp and slew limiter.
// Holds the item and configuration types, register indexes and reset values.
// No dependencies.
package csl_pkg;

    // Default number of motor channels.
    localparam int MotorsDef = 2;

    // Configuration register count and reset values.
    localparam int RegCount     = 4;
    localparam int AddrW        = 4;
    localparam logic [14:0] AbsLimitRst = 15'd5120;
    localparam logic [14:0] MotorLimRst = 15'd5120;
    localparam logic [15:0] SlewRst     = 16'd256;

    // Register indexes (word address bits of paddr).
    typedef enum logic [1:0] {
        REG_ABS_LIMIT     = 2'd0,
        REG_LIMIT_MOTOR0  = 2'd1,
        REG_LIMIT_MOTOR1  = 2'd2,
        REG_SLEW_PER_TICK = 2'd3
    } t_reg_idx;

    // Command codes of an input item.
    localparam logic CmdUpdate = 1'b0;
    localparam logic CmdZero   = 1'b1;

    // One input item.
    typedef struct packed {
        logic               cmd;
        logic [1:0]         motor_index;
        logic signed [15:0] command_current;
        logic               enable;
        logic [31:0]        now_tick;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [15:0] effective_current;
        logic               index_error;
    } t_out_item;

    // Configuration register contents handed to the datapath.
    typedef struct packed {
        logic [14:0] abs_limit;
        logic [14:0] limit_motor0;
        logic [14:0] limit_motor1;
        logic [15:0] slew_per_tick;
    } t_cfg;

endpackage

// File: rtl/core/csl_regs.sv
// APB-style configuration registers of the current clamp and slew limiter.
// Depends on csl_pkg for the register indexes, reset values and t_cfg.
module csl_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [csl_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output csl_pkg::t_cfg              o_cfg
);

    csl_pkg::t_cfg     r_cfg;
    csl_pkg::t_reg_idx reg_idx;
    logic              wr_en;

    assign reg_idx = csl_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.abs_limit     <= csl_pkg::AbsLimitRst;
            r_cfg.limit_motor0  <= csl_pkg::MotorLimRst;
            r_cfg.limit_motor1  <= csl_pkg::MotorLimRst;
            r_cfg.slew_per_tick <= csl_pkg::SlewRst;
        end else if (wr_en) begin
            unique case (reg_idx)
                csl_pkg::REG_ABS_LIMIT:     r_cfg.abs_limit     <= pwdata[14:0];
                csl_pkg::REG_LIMIT_MOTOR0:  r_cfg.limit_motor0  <= pwdata[14:0];
                csl_pkg::REG_LIMIT_MOTOR1:  r_cfg.limit_motor1  <= pwdata[14:0];
                csl_pkg::REG_SLEW_PER_TICK: r_cfg.slew_per_tick <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_idx)
            csl_pkg::REG_ABS_LIMIT:     prdata = {17'd0, r_cfg.abs_limit};
            csl_pkg::REG_LIMIT_MOTOR0:  prdata = {17'd0, r_cfg.limit_motor0};
            csl_pkg::REG_LIMIT_MOTOR1:  prdata = {17'd0, r_cfg.limit_motor1};
            csl_pkg::REG_SLEW_PER_TICK: prdata = {16'd0, r_cfg.slew_per_tick};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/core/csl_core.sv
// Per-motor state and the clamp and slew arithmetic for one item.
// Depends on csl_pkg for the item and configuration types.
module csl_core #(
    parameter int MOTORS = csl_pkg::MotorsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  csl_pkg::t_in_item   i_item,
    input  csl_pkg::t_cfg       i_cfg,
    output csl_pkg::t_out_item  o_result
);

    localparam int IdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    logic signed [15:0] r_cur   [MOTORS];
    logic [31:0]        r_last  [MOTORS];
    logic [MOTORS-1:0]  r_valid;

    logic [IdxW-1:0]    sel;
    logic               idx_bad;
    logic [14:0]        mlim;
    logic [14:0]        lim;
    logic signed [16:0] lim_s;
    logic signed [16:0] req_s;
    logic signed [16:0] target;
    logic [31:0]        elapsed;
    logic [47:0]        prod;
    logic [15:0]        step;
    logic signed [17:0] cur_s;
    logic signed [17:0] up_s;
    logic signed [17:0] dn_s;
    logic signed [17:0] tgt_s;
    logic signed [17:0] next_s;
    logic signed [15:0] n_cur;
    logic               first;

    // Channel select and range check.
    assign sel     = i_item.motor_index[IdxW-1:0];
    assign idx_bad = (32'(i_item.motor_index) >= 32'(MOTORS));

    // Clamp to the tighter of the global and per-motor magnitude limits.
    assign mlim  = (i_item.motor_index == 2'd0) ? i_cfg.limit_motor0 : i_cfg.limit_motor1;
    assign lim   = (mlim < i_cfg.abs_limit) ? mlim : i_cfg.abs_limit;
    assign lim_s = {2'b00, lim};
    assign req_s = {i_item.command_current[15], i_item.command_current};

    always_comb begin
        if (req_s > lim_s) begin
            target = lim_s;
        end else if (req_s < -lim_s) begin
            target = -lim_s;
        end else begin
            target = req_s;
        end
    end

    // Step allowed by elapsed time, saturated to 16 bits.
    assign elapsed = i_item.now_tick - r_last[sel];
    assign prod    = 48'(elapsed) * 48'(i_cfg.slew_per_tick);
    assign step    = (|prod[47:16]) ? 16'hFFFF : prod[15:0];

    // Move the held output toward the target by at most one step.
    assign cur_s = {{2{r_cur[sel][15]}}, r_cur[sel]};
    assign up_s  = cur_s + {2'b00, step};
    assign dn_s  = cur_s - {2'b00, step};
    assign tgt_s = {target[16], target};

    always_comb begin
        if (tgt_s > up_s) begin
            next_s = up_s;
        end else if (tgt_s < dn_s) begin
            next_s = dn_s;
        end else begin
            next_s = tgt_s;
        end
    end

    assign n_cur = next_s[15:0];
    assign first = !r_valid[sel];

    // Result of the item in the input register.
    always_comb begin
        o_result.index_error = idx_bad;
        if (idx_bad || i_item.cmd == csl_pkg::CmdZero || !i_item.enable) begin
            o_result.effective_current = 16'sd0;
        end else if (first) begin
            o_result.effective_current = r_cur[sel];
        end else begin
            o_result.effective_current = n_cur;
        end
    end

    // Per-motor state update when the item is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MOTORS; m++) begin
                r_cur[m]  <= 16'sd0;
                r_last[m] <= 32'd0;
            end
            r_valid <= '0;
        end else if (i_fire && !idx_bad) begin
            r_last[sel] <= i_item.now_tick;
            if (i_item.cmd == csl_pkg::CmdZero) begin
                r_cur[sel]   <= 16'sd0;
                r_valid[sel] <= 1'b0;
            end else if (!i_item.enable) begin
                r_cur[sel] <= 16'sd0;
            end else if (first) begin
                r_valid[sel] <= 1'b1;
            end else begin
                r_cur[sel] <= n_cur;
            end
        end
    end

endmodule

// File: rtl/core/current_clamp_slew_limiter.sv
// Top level of the current clamp and slew limiter.
// Depends on csl_pkg, csl_regs and csl_core.
//
// Usage: update items enter on the i_in_* channel (valid/stall) and each
// produces exactly one result item on the o_out_* channel, in order.
// An item is registered in the input register on acceptance, processed
// against the per-motor state once the result register is free, and its
// result is then registered in the result register, which drives o_out_valid.
// Throughput is one item per cycle if unstalled: motor state is written at the
// edge that registers the result, so the next item for the same motor sees
// it directly. The single 32x16 step multiply sets the cycle's logic depth.
// When the receiver stalls, the result register holds its item and the
// input register may still take one more item; o_in_stall rises only while
// both registers are full and the output is stalled.
// Reset clears both registers, all motor state and sets the configuration
// registers to their reset values. The user must write configuration over the
// APB-style port while no item is in flight; the block does not enforce it.
module current_clamp_slew_limiter #(
    parameter int MOTORS = csl_pkg::MotorsDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  csl_pkg::t_in_item          i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output csl_pkg::t_out_item         o_out_data,
    input  logic                       i_out_stall,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [csl_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    csl_pkg::t_cfg      cfg;
    csl_pkg::t_in_item  r_in;
    logic               r_in_valid;
    csl_pkg::t_out_item r_out;
    logic               r_out_valid;
    csl_pkg::t_out_item result;
    logic               out_free;
    logic               fire;
    logic               in_take;

    // Handshake: the result register frees up when empty or taken.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    csl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    csl_core #(
        .MOTORS (MOTORS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

endmodule

// File: bench/current_clamp_slew_limiter_tb.sv
// Self-checking testbench for current_clamp_slew_limiter: drives update items, predicts each
// clamped and slew-limited current, and checks results in order across several limit settings.
// Depends on csl_pkg and the current_clamp_slew_limiter RTL.
module current_clamp_slew_limiter_tb;

    import csl_pkg::*;

    localparam int Motors    = MotorsDef;
    localparam int HoldLen   = 60;
    localparam int QuietFrom = 1500;
    localparam int QuietTo   = 3500;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    t_in_item           in_data  = '0;
    logic               in_stall;
    logic               out_valid;
    t_out_item          out_data;
    logic               out_stall = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [AddrW-1:0]   paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Predicted copy of the limits and per-motor state.
    logic [14:0]        lim_abs;
    logic [14:0]        lim_motor0;
    logic [14:0]        lim_motor1;
    logic [15:0]        slew_step;
    logic signed [15:0] held_current [2];
    logic [31:0]        held_tick [2];
    logic               tick_armed [2];

    t_in_item           pending_updates [$];
    t_out_item          expected_currents [$];
    logic [31:0]        tick_now = 32'd0;
    int unsigned        cyc = 0;
    int                 errors = 0;
    int                 n_sent = 0;
    int                 n_checked = 0;
    int                 n_index_err = 0;
    int                 n_settings = 1;
    int                 stall_cycles = 0;
    int                 hold_left = 0;
    logic               held_once = 1'b0;

    current_clamp_slew_limiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // Random gaps on either side, except in one quiet window.
    function automatic logic take_break();
        if (cyc >= QuietFrom && cyc < QuietTo) begin
            return 1'b0;
        end
        return $urandom_range(99) < 8;
    endfunction

    // Clamp the request, then move the held output toward it by the elapsed slew budget.
    function automatic t_out_item predict_limited_current(t_in_item it);
        t_out_item   r;
        int          m;
        int          target;
        int          lim;
        int          cur;
        int          nxt;
        int          step;
        logic [31:0] elapsed;
        logic [63:0] prod;
        r = '0;
        m = int'(it.motor_index);
        if (m >= Motors) begin
            r.index_error = 1'b1;
            return r;
        end
        if (it.cmd == CmdZero) begin
            held_current[m] = '0;
            tick_armed[m]   = 1'b0;
            held_tick[m]    = it.now_tick;
        end else if (!it.enable) begin
            held_current[m] = '0;
            held_tick[m]    = it.now_tick;
        end else begin
            target = int'(it.command_current);
            lim = int'(lim_abs);
            if (target > lim) target = lim;
            if (target < -lim) target = -lim;
            lim = (m == 0) ? int'(lim_motor0) : int'(lim_motor1);
            if (target > lim) target = lim;
            if (target < -lim) target = -lim;
            if (!tick_armed[m]) begin
                // The first enabled update only arms the timer and returns the held value.
                held_tick[m]  = it.now_tick;
                tick_armed[m] = 1'b1;
                r.effective_current = held_current[m];
            end else begin
                elapsed = it.now_tick - held_tick[m];
                prod = {32'd0, elapsed} * {48'd0, slew_step};
                step = (prod > 64'd65535) ? 65535 : int'(prod);
                cur = int'(held_current[m]);
                if (target > cur + step) begin
                    nxt = cur + step;
                end else if (target < cur - step) begin
                    nxt = cur - step;
                end else begin
                    nxt = target;
                end
                held_tick[m]    = it.now_tick;
                held_current[m] = 16'(nxt);
                r.effective_current = 16'(nxt);
            end
        end
        return r;
    endfunction

    function automatic t_in_item update_item(logic c, int m, int cur, int en,
                                             logic [31:0] t);
        t_in_item it;
        it.cmd             = c;
        it.motor_index     = 2'(m);
        it.command_current = 16'(cur);
        it.enable          = 1'(en);
        it.now_tick        = t;
        return it;
    endfunction

    // Mostly valid motors with a slowly advancing tick; some jumps, wraps and bad indexes.
    function automatic t_in_item random_update();
        t_in_item it;
        int       roll;
        it.cmd = ($urandom_range(99) < 5) ? CmdZero : CmdUpdate;
        it.motor_index = ($urandom_range(99) < 88) ? 2'($urandom_range(Motors - 1))
                                                   : 2'($urandom_range(3));
        it.enable = ($urandom_range(99) >= 5);
        roll = $urandom_range(99);
        if (roll < 3) begin
            it.command_current = 16'sh7FFF;
        end else if (roll < 6) begin
            it.command_current = 16'sh8000;
        end else if (roll < 9) begin
            it.command_current = 16'(int'($urandom_range(2)) - 1);
        end else begin
            it.command_current = 16'($urandom);
        end
        roll = $urandom_range(99);
        if (roll < 3) begin
            tick_now = $urandom;
        end else if (roll < 5) begin
            tick_now = 32'hFFFF_FFFF - $urandom_range(16);
        end else begin
            tick_now = tick_now + $urandom_range(12);
        end
        it.now_tick = tick_now;
        return it;
    endfunction

    // Sender: predicts each accepted item and offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_stall) begin
                stall_cycles++;
            end
            if (in_valid && !in_stall) begin
                expected_currents.push_back(predict_limited_current(in_data));
                n_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_updates.size() != 0 && !take_break()) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_updates.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest prediction and decides the next stall.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_currents.size() == 0) begin
                    $display("%0t: unexpected result current=%0d index_error=%0b",
                             $time, out_data.effective_current, out_data.index_error);
                    errors++;
                end else begin
                    want = expected_currents.pop_front();
                    n_checked++;
                    if (want.index_error) n_index_err++;
                    if (out_data.effective_current !== want.effective_current) begin
                        $display("%0t: effective_current expected %0d got %0d", $time,
                                 want.effective_current, out_data.effective_current);
                        errors++;
                    end
                    if (out_data.index_error !== want.index_error) begin
                        $display("%0t: index_error expected %0b got %0b", $time,
                                 want.index_error, out_data.index_error);
                        errors++;
                    end
                end
            end
            // One long hold-off lets the block fill up and stall its input.
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!held_once && n_checked >= 150) begin
                held_once <= 1'b1;
                hold_left <= HoldLen;
                out_stall <= 1'b1;
            end else begin
                out_stall <= take_break();
            end
        end
    end

    // One register write over the configuration port; the predictor follows it.
    task automatic write_reg(input t_reg_idx r, input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_ABS_LIMIT:     lim_abs    = v[14:0];
            REG_LIMIT_MOTOR0:  lim_motor0 = v[14:0];
            REG_LIMIT_MOTOR1:  lim_motor1 = v[14:0];
            REG_SLEW_PER_TICK: slew_step  = v[15:0];
            default: ;
        endcase
    endtask

    task automatic write_limits(input int a, input int m0, input int m1, input int s);
        write_reg(REG_ABS_LIMIT, a);
        write_reg(REG_LIMIT_MOTOR0, m0);
        write_reg(REG_LIMIT_MOTOR1, m1);
        write_reg(REG_SLEW_PER_TICK, s);
        n_settings++;
    endtask

    // Wait until every queued item is accepted and every result has come back.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_updates.size() != 0 || in_valid || expected_currents.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        for (int k = 0; k < n; k++) begin
            pending_updates.push_back(random_update());
        end
    endtask

    initial begin
        lim_abs    = AbsLimitRst;
        lim_motor0 = MotorLimRst;
        lim_motor1 = MotorLimRst;
        slew_step  = SlewRst;
        for (int m = 0; m < 2; m++) begin
            held_current[m] = '0;
            held_tick[m]    = '0;
            tick_armed[m]   = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset limits.
        pending_updates.push_back(update_item(CmdUpdate, 0, 1000, 1, 100));
        pending_updates.push_back(update_item(CmdUpdate, 0, 32767, 1, 101));
        pending_updates.push_back(update_item(CmdUpdate, 0, 32767, 1, 101));
        pending_updates.push_back(update_item(CmdUpdate, 0, 32767, 1, 200));
        pending_updates.push_back(update_item(CmdUpdate, 0, -32768, 1, 201));
        pending_updates.push_back(update_item(CmdUpdate, 0, -1, 1, 300));
        pending_updates.push_back(update_item(CmdUpdate, 0, 1234, 0, 301));
        pending_updates.push_back(update_item(CmdUpdate, 0, 1234, 1, 302));
        pending_updates.push_back(update_item(CmdZero, 0, 500, 1, 303));
        pending_updates.push_back(update_item(CmdUpdate, 0, 500, 1, 304));
        pending_updates.push_back(update_item(CmdUpdate, 1, -32768, 1, 32'hFFFF_FFF0));
        pending_updates.push_back(update_item(CmdUpdate, 1, -32768, 1, 32'h0000_0004));
        pending_updates.push_back(update_item(CmdUpdate, 1, 0, 1, 32'h0000_0004));
        pending_updates.push_back(update_item(CmdUpdate, 1, 0, 1, 32'h0000_0005));
        pending_updates.push_back(update_item(CmdUpdate, 2, 4000, 1, 32'h0000_0006));
        pending_updates.push_back(update_item(CmdUpdate, 3, 32767, 1, 32'hFFFF_FFFF));
        pending_updates.push_back(update_item(CmdZero, 3, -32768, 0, 32'h0000_0000));
        pending_updates.push_back(update_item(CmdZero, 1, -32768, 0, 32'hFFFF_FFFF));
        pending_updates.push_back(update_item(CmdUpdate, 1, 5120, 1, 32'h0000_0010));
        pending_updates.push_back(update_item(CmdUpdate, 1, 32767, 1, 32'h0000_1000));
        pending_updates.push_back(update_item(CmdUpdate, 1, -5121, 1, 32'h0000_1001));
        pending_updates.push_back(update_item(CmdUpdate, 0, 0, 0, 32'h0000_0000));
        tick_now = 32'h0000_2000;
        queue_random(300);
        drain();

        // Limit and slew settings, extremes first, then random ones.
        write_limits(32767, 32767, 1000, 65535);
        queue_random(260);
        drain();
        write_limits(0, 32767, 32767, 0);
        queue_random(260);
        drain();
        write_limits(20000, 0, 32767, 1);
        queue_random(260);
        drain();
        write_limits(32767, 32767, 0, 3);
        queue_random(260);
        drain();
        for (int p = 0; p < 2; p++) begin
            write_limits($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                         $urandom_range(1500));
            queue_random(260);
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("Sent %0d items under %0d limit settings; %0d results checked, %0d bad index.",
                 n_sent, n_settings, n_checked, n_index_err);
        $display("Input was held off by the block on %0d cycles.", stall_cycles);
        if (errors == 0 && expected_currents.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/csl_pkg.sv
rtl/core/csl_regs.sv
rtl/core/csl_core.sv
rtl/core/current_clamp_slew_limiter.sv
bench/current_clamp_slew_limiter_tb.sv
